>>> sv/rc4_pkg.sv
// Shared types and constants of the RC4 stream cipher core.
`default_nettype none
package rc4_pkg;

  localparam int unsigned PERM_DEPTH = 256;
  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned COUNT_W    = 9;

  typedef logic [BYTE_W-1:0]  byte_t;
  typedef logic [COUNT_W-1:0] count_t;

  localparam logic ACTION_KEY  = 1'b0;
  localparam logic ACTION_DATA = 1'b1;

  localparam byte_t BYTE_LAST = 8'hFF;

endpackage
`default_nettype wire

>>> sv/rc4_stream_cipher_core.sv
// RC4 stream cipher core: a key store, and key schedule and keystream XOR on one permutation RAM.
//
// Key bytes (action 0) are accepted one per cycle while the core is idle and stored, up to
// MAX_KEY_BYTES; later ones are dropped. A key byte with key_last set starts the key schedule:
// the permutation RAM is filled with identity, then 256 swap steps follow (read S[n] and key
// byte, read S[acc], write back both entries), and the next transaction is taken only after the
// schedule ends. A data byte (action 1) yields one result: when keyed, it goes through read
// S[i], read S[j], write S[i], write S[j] with the keystream read, then output to the result
// register; when no key has been scheduled yet, the byte passes unchanged with not_keyed set.
// The permutation RAM has one write and one registered read port, so each RAM read takes its
// own step. The result register lets the next transaction be accepted while a result still
// waits on out_ready.
`default_nettype none
module rc4_stream_cipher_core
  import rc4_pkg::*;
#(
  parameter int unsigned MAX_KEY_BYTES = 256
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        in_action,
  input  wire logic [7:0]  in_data_byte,
  input  wire logic        in_key_last,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [7:0]       out_byte,
  output logic             out_not_keyed
);

  typedef enum logic [3:0] {
    S_IDLE, S_FILL, S_KA, S_KB, S_KC, S_KD, S_DA, S_DB, S_DC, S_DD, S_EMIT
  } state_t;

  localparam count_t KEY_LIMIT = COUNT_W'(MAX_KEY_BYTES);

  state_t state_r, state_nxt;
  count_t key_count_r, key_count_nxt;
  byte_t  i_r, i_nxt, j_r, j_nxt;
  byte_t  n_r, n_nxt, k_r, k_nxt, acc_r, acc_nxt;
  byte_t  sa_r, sa_nxt, sb_r, sb_nxt;
  byte_t  byte_r, byte_nxt;
  logic   keyed_r, keyed_nxt;
  logic   nk_r, nk_nxt;
  logic   fwd_r, fwd_nxt;
  logic   out_valid_r, out_valid_nxt;
  byte_t  out_byte_r, out_byte_nxt;
  logic   out_nk_r, out_nk_nxt;

  byte_t perm_mem [PERM_DEPTH];
  byte_t key_mem  [PERM_DEPTH];
  byte_t perm_rd_r, key_rd_r;

  logic  perm_we, perm_re, key_we, key_re;
  byte_t perm_wa, perm_wd, perm_ra, key_ra;

  logic  accept;
  logic  slot_free;
  byte_t sum_b, ks;

  always_ff @(posedge clk) begin
    if (perm_we) begin
      perm_mem[perm_wa] <= perm_wd;
    end
    if (perm_re) begin
      perm_rd_r <= perm_mem[perm_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (key_we) begin
      key_mem[key_count_r[BYTE_W-1:0]] <= in_data_byte;
    end
    if (key_re) begin
      key_rd_r <= key_mem[key_ra];
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign slot_free = !out_valid_r || out_ready;
  assign sum_b     = sa_r + sb_r;
  assign ks        = fwd_r ? sa_r : perm_rd_r;

  always_comb begin
    state_nxt     = state_r;
    key_count_nxt = key_count_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    n_nxt         = n_r;
    k_nxt         = k_r;
    acc_nxt       = acc_r;
    sa_nxt        = sa_r;
    sb_nxt        = sb_r;
    byte_nxt      = byte_r;
    keyed_nxt     = keyed_r;
    nk_nxt        = nk_r;
    fwd_nxt       = fwd_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_byte_nxt  = out_byte_r;
    out_nk_nxt    = out_nk_r;
    perm_we       = 1'b0;
    perm_re       = 1'b0;
    perm_wa       = n_r;
    perm_wd       = n_r;
    perm_ra       = n_r;
    key_we        = 1'b0;
    key_re        = 1'b0;
    key_ra        = k_r;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_action == ACTION_KEY) begin
            if (key_count_r < KEY_LIMIT) begin
              key_we        = 1'b1;
              key_count_nxt = key_count_r + 1'b1;
            end
            if (in_key_last) begin
              n_nxt     = '0;
              state_nxt = S_FILL;
            end
          end else begin
            byte_nxt = in_data_byte;
            fwd_nxt  = 1'b0;
            if (keyed_r) begin
              nk_nxt    = 1'b0;
              i_nxt     = i_r + 1'b1;
              state_nxt = S_DA;
            end else begin
              nk_nxt    = 1'b1;
              state_nxt = S_EMIT;
            end
          end
        end
      end
      S_FILL: begin
        perm_we = 1'b1;
        n_nxt   = n_r + 1'b1;
        if (n_r == BYTE_LAST) begin
          acc_nxt   = '0;
          k_nxt     = '0;
          state_nxt = S_KA;
        end
      end
      S_KA: begin
        perm_re   = 1'b1;
        key_re    = 1'b1;
        state_nxt = S_KB;
      end
      S_KB: begin
        sa_nxt    = perm_rd_r;
        acc_nxt   = acc_r + perm_rd_r + key_rd_r;
        perm_re   = 1'b1;
        perm_ra   = acc_nxt;
        state_nxt = S_KC;
      end
      S_KC: begin
        perm_we   = 1'b1;
        perm_wd   = perm_rd_r;
        state_nxt = S_KD;
      end
      S_KD: begin
        perm_we = 1'b1;
        perm_wa = acc_r;
        perm_wd = sa_r;
        n_nxt   = n_r + 1'b1;
        if ((COUNT_W'(k_r) + 1'b1) >= key_count_r) begin
          k_nxt = '0;
        end else begin
          k_nxt = k_r + 1'b1;
        end
        if (n_r == BYTE_LAST) begin
          i_nxt         = '0;
          j_nxt         = '0;
          key_count_nxt = '0;
          keyed_nxt     = 1'b1;
          state_nxt     = S_IDLE;
        end else begin
          state_nxt = S_KA;
        end
      end
      S_DA: begin
        perm_re   = 1'b1;
        perm_ra   = i_r;
        state_nxt = S_DB;
      end
      S_DB: begin
        sa_nxt    = perm_rd_r;
        j_nxt     = j_r + perm_rd_r;
        perm_re   = 1'b1;
        perm_ra   = j_nxt;
        state_nxt = S_DC;
      end
      S_DC: begin
        sb_nxt    = perm_rd_r;
        perm_we   = 1'b1;
        perm_wa   = i_r;
        perm_wd   = perm_rd_r;
        state_nxt = S_DD;
      end
      S_DD: begin
        perm_we   = 1'b1;
        perm_wa   = j_r;
        perm_wd   = sa_r;
        perm_re   = 1'b1;
        perm_ra   = sum_b;
        fwd_nxt   = (sum_b == j_r);
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_byte_nxt  = nk_r ? byte_r : (byte_r ^ ks);
          out_nk_nxt    = nk_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      key_count_r <= '0;
      i_r         <= '0;
      j_r         <= '0;
      keyed_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      key_count_r <= key_count_nxt;
      i_r         <= i_nxt;
      j_r         <= j_nxt;
      keyed_r     <= keyed_nxt;
      out_valid_r <= out_valid_nxt;
    end
    n_r        <= n_nxt;
    k_r        <= k_nxt;
    acc_r      <= acc_nxt;
    sa_r       <= sa_nxt;
    sb_r       <= sb_nxt;
    byte_r     <= byte_nxt;
    nk_r       <= nk_nxt;
    fwd_r      <= fwd_nxt;
    out_byte_r <= out_byte_nxt;
    out_nk_r   <= out_nk_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_byte      = out_byte_r;
  assign out_not_keyed = out_nk_r;

endmodule
`default_nettype wire

>>> sv/rc4_checker.sv
// Port-level checker for the RC4 stream cipher core, bound into the core module.
`default_nettype none
module rc4_checker
  import rc4_pkg::*;
(
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_valid,
  input wire logic       in_ready,
  input wire logic       in_action,
  input wire logic [7:0] in_data_byte,
  input wire logic       in_key_last,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [7:0] out_byte,
  input wire logic       out_not_keyed
);

  logic in_acc;
  assign in_acc = in_valid && in_ready;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(out_not_keyed))
    else $error("result changed while stalled");

  a_key_fast: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_action == ACTION_KEY && !in_key_last |=> in_ready)
    else $error("plain key byte did not free the input in one cycle");

  a_sched_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_action == ACTION_KEY && in_key_last |=> !in_ready)
    else $error("input ready during key schedule");

  a_data_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_action == ACTION_DATA |=> !in_ready)
    else $error("input ready while a data byte is in work");

  a_data_byte_known: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |-> !$isunknown(in_data_byte))
    else $error("accepted byte has unknown bits");

endmodule

bind rc4_stream_cipher_core rc4_checker u_rc4_checker (.*);
`default_nettype wire
